>>> hdl/avk_pkg.sv
`timescale 1ns / 1ps
// Package for the altitude/velocity Kalman core: defaults, register indexes,
// micro-operation codes and the update micro-program. No dependencies.
package avk_pkg;

  // default configuration of the core
  localparam int DEF_FRAC_BITS        = 16;
  localparam int DEF_STATE_WIDTH      = 48;
  localparam int DEF_TICKS_PER_SECOND = 1000;

  // multiplier digit: bits of the second operand taken per cycle
  localparam int MUL_DIGIT = 16;

  // variance registers come out of reset at 1.0
  localparam logic [31:0] VARIANCE_RESET = 32'h0001_0000;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_POS_VARIANCE   = 3'd0,
    CFG_ACCEL_VARIANCE = 3'd1,
    CFG_START_POSITION = 3'd2,
    CFG_START_ACCEL    = 3'd3,
    CFG_START_TIME     = 3'd4
  } cfg_reg_t;

  // shared unit operations
  typedef enum logic [1:0] {
    ALU_ADD = 2'd0,
    ALU_SUB = 2'd1,
    ALU_MUL = 2'd2,
    ALU_DIV = 2'd3
  } alu_op_t;

  // scaling applied to a result before write back (truncating toward zero)
  typedef enum logic [1:0] {
    POST_NONE    = 2'd0,
    POST_HALF    = 2'd1,
    POST_QUARTER = 2'd2
  } post_t;

  // operand and destination selects
  typedef enum logic [4:0] {
    OPD_POS   = 5'd0,
    OPD_VEL   = 5'd1,
    OPD_CPP   = 5'd2,
    OPD_CPV   = 5'd3,
    OPD_CVP   = 5'd4,
    OPD_CVV   = 5'd5,
    OPD_DT    = 5'd6,
    OPD_DT2   = 5'd7,
    OPD_DT3   = 5'd8,
    OPD_DT4   = 5'd9,
    OPD_T1    = 5'd10,
    OPD_T2    = 5'd11,
    OPD_INC   = 5'd12,
    OPD_K11   = 5'd13,
    OPD_K12   = 5'd14,
    OPD_ACC   = 5'd15,
    OPD_Q     = 5'd16,
    OPD_RV    = 5'd17,
    OPD_MP    = 5'd18,
    OPD_DELTA = 5'd19,
    OPD_TICKS = 5'd20
  } opnd_t;

  typedef struct packed {
    alu_op_t op;
    opnd_t   a;
    opnd_t   b;
    opnd_t   d;
    post_t   post;
  } uinst_t;

  localparam int          UC_PC_W = 6;
  localparam logic [5:0]  UC_LAST = 6'd38;

  // update sequence: predict, gain, correct
  function automatic uinst_t ucode(input logic [UC_PC_W-1:0] pc);
    uinst_t u;
    u = '{ALU_ADD, OPD_T1, OPD_T1, OPD_T1, POST_NONE};
    unique case (pc)
      // elapsed time and its powers, state prediction
      6'd0:  u = '{ALU_DIV, OPD_DELTA, OPD_TICKS, OPD_DT,  POST_NONE};
      6'd1:  u = '{ALU_MUL, OPD_DT,    OPD_DT,    OPD_DT2, POST_NONE};
      6'd2:  u = '{ALU_MUL, OPD_DT,    OPD_VEL,   OPD_T1,  POST_NONE};
      6'd3:  u = '{ALU_MUL, OPD_DT2,   OPD_ACC,   OPD_T2,  POST_HALF};
      6'd4:  u = '{ALU_ADD, OPD_T1,    OPD_T2,    OPD_T1,  POST_NONE};
      6'd5:  u = '{ALU_ADD, OPD_POS,   OPD_T1,    OPD_POS, POST_NONE};
      6'd6:  u = '{ALU_MUL, OPD_DT,    OPD_ACC,   OPD_T1,  POST_NONE};
      6'd7:  u = '{ALU_ADD, OPD_VEL,   OPD_T1,    OPD_VEL, POST_NONE};
      // covariance prediction
      6'd8:  u = '{ALU_MUL, OPD_DT2,   OPD_DT,    OPD_DT3, POST_NONE};
      6'd9:  u = '{ALU_MUL, OPD_DT,    OPD_CVV,   OPD_T1,  POST_NONE};
      6'd10: u = '{ALU_MUL, OPD_DT3,   OPD_Q,     OPD_T2,  POST_HALF};
      6'd11: u = '{ALU_ADD, OPD_T1,    OPD_T2,    OPD_INC, POST_NONE};
      6'd12: u = '{ALU_MUL, OPD_DT3,   OPD_DT,    OPD_DT4, POST_NONE};
      6'd13: u = '{ALU_ADD, OPD_CPV,   OPD_CVP,   OPD_T1,  POST_NONE};
      6'd14: u = '{ALU_ADD, OPD_T1,    OPD_INC,   OPD_T1,  POST_NONE};
      6'd15: u = '{ALU_MUL, OPD_DT,    OPD_T1,    OPD_T1,  POST_NONE};
      6'd16: u = '{ALU_MUL, OPD_DT4,   OPD_Q,     OPD_T2,  POST_QUARTER};
      6'd17: u = '{ALU_SUB, OPD_T1,    OPD_T2,    OPD_T1,  POST_NONE};
      6'd18: u = '{ALU_ADD, OPD_CPP,   OPD_T1,    OPD_CPP, POST_NONE};
      6'd19: u = '{ALU_ADD, OPD_CVP,   OPD_INC,   OPD_CVP, POST_NONE};
      6'd20: u = '{ALU_ADD, OPD_CPV,   OPD_INC,   OPD_CPV, POST_NONE};
      6'd21: u = '{ALU_MUL, OPD_DT2,   OPD_Q,     OPD_T1,  POST_NONE};
      6'd22: u = '{ALU_ADD, OPD_CVV,   OPD_T1,    OPD_CVV, POST_NONE};
      // gains, innovation sum held in t2
      6'd23: u = '{ALU_ADD, OPD_CPP,   OPD_RV,    OPD_T2,  POST_NONE};
      6'd24: u = '{ALU_DIV, OPD_CPP,   OPD_T2,    OPD_K11, POST_NONE};
      6'd25: u = '{ALU_DIV, OPD_CPV,   OPD_T2,    OPD_K12, POST_NONE};
      // correction, innovation held in t2
      6'd26: u = '{ALU_SUB, OPD_MP,    OPD_POS,   OPD_T2,  POST_NONE};
      6'd27: u = '{ALU_MUL, OPD_K11,   OPD_T2,    OPD_T1,  POST_NONE};
      6'd28: u = '{ALU_ADD, OPD_POS,   OPD_T1,    OPD_POS, POST_NONE};
      6'd29: u = '{ALU_MUL, OPD_K12,   OPD_T2,    OPD_T1,  POST_NONE};
      6'd30: u = '{ALU_ADD, OPD_VEL,   OPD_T1,    OPD_VEL, POST_NONE};
      6'd31: u = '{ALU_MUL, OPD_K12,   OPD_CVP,   OPD_T1,  POST_NONE};
      6'd32: u = '{ALU_SUB, OPD_CVV,   OPD_T1,    OPD_CVV, POST_NONE};
      6'd33: u = '{ALU_MUL, OPD_K12,   OPD_CPP,   OPD_T1,  POST_NONE};
      6'd34: u = '{ALU_SUB, OPD_CPV,   OPD_T1,    OPD_CPV, POST_NONE};
      6'd35: u = '{ALU_MUL, OPD_K11,   OPD_CVP,   OPD_T1,  POST_NONE};
      6'd36: u = '{ALU_SUB, OPD_CVP,   OPD_T1,    OPD_CVP, POST_NONE};
      6'd37: u = '{ALU_MUL, OPD_K11,   OPD_CPP,   OPD_T1,  POST_NONE};
      6'd38: u = '{ALU_SUB, OPD_CPP,   OPD_T1,    OPD_CPP, POST_NONE};
      default: u = '{ALU_ADD, OPD_T1, OPD_T1, OPD_T1, POST_NONE};
    endcase
    return u;
  endfunction

endpackage

>>> hdl/altitude_velocity_kalman_core.sv
`timescale 1ns / 1ps
// Two-state altitude/velocity Kalman filter core with a shared arithmetic unit.
// Depends on avk_pkg for defaults, codes and the update micro-program.
//
// An update word runs a 39-step micro-program through one shared saturating
// unit (add/subtract, digit-serial multiply, restoring divide), so the core
// takes one word at a time and in_ready is low until that word's result is
// queued. An update has 19 adds, 17 multiplies and 3 divides; the default
// state is 48 bits with 16 fraction bits, and the divider produces one
// quotient bit per cycle. A calibrate word goes through the calibrate and
// done states. The result word sits in an output register, and the next
// input word is taken while it waits. Configuration writes take effect at
// once; the user must make them only while idle, as the core itself does
// not enforce this.
module altitude_velocity_kalman_core #(
  parameter int FRAC_BITS        = avk_pkg::DEF_FRAC_BITS,
  parameter int STATE_WIDTH      = avk_pkg::DEF_STATE_WIDTH,
  parameter int TICKS_PER_SECOND = avk_pkg::DEF_TICKS_PER_SECOND
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               command,
  input  logic signed [31:0] measured_position,
  input  logic signed [31:0] measured_accel,
  input  logic [31:0]        sample_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] position,
  output logic signed [31:0] calibrated_position,
  output logic signed [31:0] velocity,
  output logic signed [31:0] acceleration,
  output logic [31:0]        last_time
);
  import avk_pkg::*;

  localparam int SW  = STATE_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int NCH = (SW + MUL_DIGIT - 1) / MUL_DIGIT;
  localparam int BW  = NCH * MUL_DIGIT;
  localparam int PW  = SW + BW;
  localparam int NW  = SW + F;
  localparam int UW  = PW + F;
  localparam int CW  = $clog2(NW + 1);

  localparam logic [UW-1:0]        SMAX_U  = UW'({(SW-1){1'b1}});
  localparam logic [UW-1:0]        SMIN_U  = SMAX_U + UW'(1);
  localparam logic [SW:0]          Q_MAX   = {2'b00, {(SW-1){1'b1}}};
  localparam logic signed [SW+1:0] S_MAX_X = $signed({3'b000, {(SW-1){1'b1}}});
  localparam logic signed [SW+1:0] S_MIN_X = $signed({3'b111, {(SW-1){1'b0}}});
  localparam logic signed [SW+1:0] MAX32_X = (SW+2)'(64'sd2147483647);
  localparam logic signed [SW+1:0] MIN32_X = (SW+2)'(-64'sd2147483648);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_FETCH = 9'b000000010,
    ST_ADD   = 9'b000000100,
    ST_MUL   = 9'b000001000,
    ST_DIV   = 9'b000010000,
    ST_SAT   = 9'b000100000,
    ST_WB    = 9'b001000000,
    ST_CAL   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state;
  logic [UC_PC_W-1:0] pc;
  uinst_t ui;

  // filter state and scratch registers
  logic signed [SW-1:0] est_position, est_velocity;
  logic signed [SW-1:0] cov_pp, cov_pv, cov_vp, cov_vv;
  logic signed [SW-1:0] dt, dt2, dt3, dt4, tmp1, tmp2, incr, k11, k12, res;
  logic signed [31:0]   est_accel, drift, meas_pos;
  logic [31:0]          prev_time, delta, pos_variance, accel_variance;

  // shared unit registers
  logic signed [SW:0] opa, opb;
  logic [SW-1:0]      a_mag, rem;
  logic [BW-1:0]      b_sh;
  logic               neg;
  logic [PW-1:0]      acc;
  logic [NW-1:0]      num_sh, quo;
  logic [CW-1:0]      cnt;

  logic signed [SW:0]   va, vb;
  logic [SW:0]          q_ext, rv_ext, rem_sh, rem_dif;
  logic signed [SW+1:0] sum, cal_dif, cal_sum;
  logic [UW-1:0]        mag_u, lim_u, sat_u;
  logic signed [SW-1:0] post_v, half_v, quar_v;

  function automatic logic [SW-1:0] mag_of(input logic signed [SW:0] x);
    logic [SW:0] t;
    t = x[SW] ? -x : x;
    return t[SW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SW+1:0] v);
    logic signed [SW+1:0] c;
    c = v;
    if (v > MAX32_X) c = MAX32_X;
    if (v < MIN32_X) c = MIN32_X;
    return c[31:0];
  endfunction

  function automatic logic signed [SW:0] opnd(input opnd_t c);
    logic signed [SW:0] v;
    v = '0;
    unique case (c)
      OPD_POS:   v = (SW+1)'(est_position);
      OPD_VEL:   v = (SW+1)'(est_velocity);
      OPD_CPP:   v = (SW+1)'(cov_pp);
      OPD_CPV:   v = (SW+1)'(cov_pv);
      OPD_CVP:   v = (SW+1)'(cov_vp);
      OPD_CVV:   v = (SW+1)'(cov_vv);
      OPD_DT:    v = (SW+1)'(dt);
      OPD_DT2:   v = (SW+1)'(dt2);
      OPD_DT3:   v = (SW+1)'(dt3);
      OPD_DT4:   v = (SW+1)'(dt4);
      OPD_T1:    v = (SW+1)'(tmp1);
      OPD_T2:    v = (SW+1)'(tmp2);
      OPD_INC:   v = (SW+1)'(incr);
      OPD_K11:   v = (SW+1)'(k11);
      OPD_K12:   v = (SW+1)'(k12);
      OPD_ACC:   v = (SW+1)'(est_accel);
      OPD_Q:     v = $signed((q_ext > Q_MAX) ? Q_MAX : q_ext);
      OPD_RV:    v = $signed((rv_ext > Q_MAX) ? Q_MAX : rv_ext);
      OPD_MP:    v = (SW+1)'(meas_pos);
      OPD_DELTA: v = $signed((SW+1)'(delta));
      OPD_TICKS: v = $signed((SW+1)'(TICKS_PER_SECOND));
      default:   v = '0;
    endcase
    return v;
  endfunction

  assign ui       = ucode(pc);
  assign in_ready = (state == ST_IDLE);

  // operand selection and unit datapath
  always_comb begin
    q_ext   = (SW+1)'(accel_variance);
    rv_ext  = (SW+1)'(pos_variance);
    va      = opnd(ui.a);
    vb      = opnd(ui.b);
    rem_sh  = {rem, num_sh[NW-1]};
    rem_dif = rem_sh - {1'b0, b_sh[SW-1:0]};
    if (ui.op == ALU_SUB) begin
      sum = (SW+2)'(opa) - (SW+2)'(opb);
    end else begin
      sum = (SW+2)'(opa) + (SW+2)'(opb);
    end
    mag_u = (ui.op == ALU_MUL) ? UW'(acc >> F) : UW'(quo);
    lim_u = neg ? SMIN_U : SMAX_U;
    sat_u = (mag_u > lim_u) ? lim_u : mag_u;
    if (ui.op == ALU_DIV && b_sh[SW-1:0] == '0) begin
      sat_u = '0;
    end
    half_v = (res + $signed({{(SW-1){1'b0}}, res[SW-1]})) >>> 1;
    quar_v = (res + $signed({{(SW-2){1'b0}}, res[SW-1], res[SW-1]})) >>> 2;
    case (ui.post)
      POST_HALF:    post_v = half_v;
      POST_QUARTER: post_v = quar_v;
      default:      post_v = res;
    endcase
    cal_dif = (SW+2)'(meas_pos) - (SW+2)'(est_position);
    cal_sum = (SW+2)'(est_position) + (SW+2)'(drift);
  end

  // sequencer, shared unit and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pc             <= '0;
      out_valid      <= 1'b0;
      pos_variance   <= VARIANCE_RESET;
      accel_variance <= VARIANCE_RESET;
      est_position   <= '0;
      est_velocity   <= '0;
      est_accel      <= '0;
      prev_time      <= '0;
      cov_pp         <= '0;
      cov_pv         <= '0;
      cov_vp         <= '0;
      cov_vv         <= '0;
      drift          <= '0;
    end else begin
      // result taken; a finishing word reloads the register below
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end

      // configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_POS_VARIANCE:   pos_variance   <= cfg_data;
          CFG_ACCEL_VARIANCE: accel_variance <= cfg_data;
          CFG_START_POSITION: est_position   <= SW'($signed(cfg_data));
          CFG_START_ACCEL:    est_accel      <= $signed(cfg_data);
          CFG_START_TIME:     prev_time      <= cfg_data;
          default: ;
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            meas_pos <= measured_position;
            if (command) begin
              state <= ST_CAL;
            end else begin
              delta     <= sample_time - prev_time;
              prev_time <= sample_time;
              est_accel <= measured_accel;
              pc        <= '0;
              state     <= ST_FETCH;
            end
          end
        end
        ST_FETCH: begin
          opa    <= va;
          opb    <= vb;
          a_mag  <= mag_of(va);
          b_sh   <= BW'(mag_of(vb));
          neg    <= va[SW] ^ vb[SW];
          acc    <= '0;
          rem    <= '0;
          quo    <= '0;
          num_sh <= {mag_of(va), {F{1'b0}}};
          cnt    <= '0;
          case (ui.op)
            ALU_MUL: state <= ST_MUL;
            ALU_DIV: state <= ST_DIV;
            default: state <= ST_ADD;
          endcase
        end
        ST_ADD: begin
          if (sum > S_MAX_X) begin
            res <= S_MAX_X[SW-1:0];
          end else if (sum < S_MIN_X) begin
            res <= S_MIN_X[SW-1:0];
          end else begin
            res <= sum[SW-1:0];
          end
          state <= ST_WB;
        end
        ST_MUL: begin
          // one 16-bit digit of the second operand per cycle, top digit first
          acc  <= (acc << MUL_DIGIT) + PW'(a_mag) * PW'(b_sh[BW-1 -: MUL_DIGIT]);
          b_sh <= b_sh << MUL_DIGIT;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(NCH - 1)) begin
            state <= ST_SAT;
          end
        end
        ST_DIV: begin
          // restoring divide, one quotient bit per cycle
          if (rem_sh >= {1'b0, b_sh[SW-1:0]}) begin
            rem <= rem_dif[SW-1:0];
            quo <= {quo[NW-2:0], 1'b1};
          end else begin
            rem <= rem_sh[SW-1:0];
            quo <= {quo[NW-2:0], 1'b0};
          end
          num_sh <= num_sh << 1;
          cnt    <= cnt + CW'(1);
          if (cnt == CW'(NW - 1)) begin
            state <= ST_SAT;
          end
        end
        ST_SAT: begin
          res   <= neg ? -$signed(sat_u[SW-1:0]) : $signed(sat_u[SW-1:0]);
          state <= ST_WB;
        end
        ST_WB: begin
          case (ui.d)
            OPD_POS: est_position <= post_v;
            OPD_VEL: est_velocity <= post_v;
            OPD_CPP: cov_pp       <= post_v;
            OPD_CPV: cov_pv       <= post_v;
            OPD_CVP: cov_vp       <= post_v;
            OPD_CVV: cov_vv       <= post_v;
            OPD_DT:  dt           <= post_v;
            OPD_DT2: dt2          <= post_v;
            OPD_DT3: dt3          <= post_v;
            OPD_DT4: dt4          <= post_v;
            OPD_T2:  tmp2         <= post_v;
            OPD_INC: incr         <= post_v;
            OPD_K11: k11          <= post_v;
            OPD_K12: k12          <= post_v;
            default: tmp1         <= post_v;
          endcase
          pc <= pc + UC_PC_W'(1);
          if (pc == UC_LAST) begin
            state <= ST_DONE;
          end else begin
            state <= ST_FETCH;
          end
        end
        ST_CAL: begin
          drift <= sat32(cal_dif);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            position            <= sat32((SW+2)'(est_position));
            calibrated_position <= sat32(cal_sum);
            velocity            <= sat32((SW+2)'(est_velocity));
            acceleration        <= est_accel;
            last_time           <= prev_time;
            out_valid           <= 1'b1;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // a word accepted leaves idle on the next cycle
  a_leave_idle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state != ST_IDLE))
    else $error("core stayed idle after accepting a word");

  // the micro-program never runs past its last step
  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FETCH) |-> (pc <= UC_LAST))
    else $error("micro-program counter out of range");

  // a zero divisor yields a zero quotient
  a_div_zero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SAT && ui.op == ALU_DIV && b_sh[SW-1:0] == '0) |=> (res == '0))
    else $error("divide by zero did not give zero");

  // calibrate leaves the filter state alone
  a_cal_keeps: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CAL) |=> ($stable(cov_pp) && $stable(est_velocity) &&
                           $stable(est_position)))
    else $error("calibrate changed filter state");

endmodule
